[src/solve_3x3_linear_system_core_assert.svh]
// assertion macros used by the solver core
`ifndef SOLVE_3X3_LINEAR_SYSTEM_CORE_ASSERT_SVH
`define SOLVE_3X3_LINEAR_SYSTEM_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define S3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define S3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/s3ls_pkg.sv]
package s3ls_pkg;

    // determinant width: |det| < 2^48, one spare bit
    localparam int DetW = 50;
    // quotient bits: numerator |N|*2^16 < 2^64, quotient kept to 34 bits
    localparam int QW = 34;
    localparam int DivW = 66;
    // divider stages after the load stage, one quotient bit per stage
    localparam int DivStages = QW;

    localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [31:0] SatNeg = 32'h8000_0000;

    typedef logic signed [15:0] q88_t;
    typedef logic signed [DetW-1:0] det_t;

    // sideband carried along with the divider lanes
    typedef struct packed {
        logic singular;
    } side_t;

endpackage

[src/s3ls_det.sv]
// four 3x3 determinants in three register stages, stalls with the pipe
module s3ls_det (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  s3ls_pkg::q88_t         m [9],
    input  s3ls_pkg::q88_t         b [3],
    output logic                   out_valid,
    output s3ls_pkg::det_t         det_out [4]
);

    // stage 1: 2x2 minor products
    logic signed [31:0] p_reg [4][6];
    logic signed [15:0] top_reg [4][3];
    // stage 2: minors
    logic signed [32:0] mn_reg [4][3];
    logic signed [15:0] top2_reg [4][3];
    // stage 3: weighted minors
    logic signed [48:0] w_reg [4][3];
    logic [2:0] v_reg;
    logic signed [15:0] mm [4][9];

    // build the four matrices: A, then column j replaced by b
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            for (int i = 0; i < 9; i++)
                mm[k][i] = m[i];
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
                mm[j+1][i*3+j] = b[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], in_valid};
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p_reg[k][0] <= mm[k][4] * mm[k][8];
                p_reg[k][1] <= mm[k][5] * mm[k][7];
                p_reg[k][2] <= mm[k][3] * mm[k][8];
                p_reg[k][3] <= mm[k][5] * mm[k][6];
                p_reg[k][4] <= mm[k][3] * mm[k][7];
                p_reg[k][5] <= mm[k][4] * mm[k][6];
                for (int i = 0; i < 3; i++)
                    top_reg[k][i] <= mm[k][i];
                for (int i = 0; i < 3; i++)
                begin
                    mn_reg[k][i] <= 33'(p_reg[k][2*i]) - 33'(p_reg[k][2*i+1]);
                    top2_reg[k][i] <= top_reg[k][i];
                    w_reg[k][i] <= 49'(top2_reg[k][i]) * 49'(mn_reg[k][i]);
                end
            end
        end
    end

    assign out_valid = v_reg[2];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            det_out[k] = s3ls_pkg::DetW'(w_reg[k][0]) - s3ls_pkg::DetW'(w_reg[k][1])
                       + s3ls_pkg::DetW'(w_reg[k][2]);
    end

endmodule

[src/s3ls_div.sv]
// pipelined restoring divider, one quotient bit per stage, three lanes
module s3ls_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  s3ls_pkg::det_t             den,
    input  s3ls_pkg::det_t             num [3],
    output logic                       out_valid,
    output logic [s3ls_pkg::QW-1:0]    quo [3],
    output logic [2:0]                 neg,
    output s3ls_pkg::side_t            side
);

    localparam int QW = s3ls_pkg::QW;
    localparam int DW = s3ls_pkg::DetW;
    // magnitude bits shifted in by the stages, the rest is preloaded
    localparam int HI = QW - 16;

    logic [DW-1:0]  d_reg [QW+1];
    logic [DW:0]    r_reg [QW+1][3];
    logic [63:0]    n_reg [QW+1][3];
    logic [QW-1:0]  q_reg [QW+1][3];
    logic [2:0]     ng_reg [QW+1];
    logic [2:0]     ov_reg [QW+1];
    s3ls_pkg::side_t sd_reg [QW+1];
    logic [QW:0]    v_reg;
    logic [DW-1:0]  uden;
    logic [DW-1:0]  unum [3];

    assign uden = den[DW-1] ? DW'(-den) : DW'(den);

    // numerator magnitudes
    always_comb
    begin
        for (int l = 0; l < 3; l++)
            unum[l] = num[l][DW-1] ? DW'(-num[l]) : DW'(num[l]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW-1:0], in_valid};
    end

    // stage 0 preloads the top of |N|*2^16, each later stage retires one bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= uden;
            sd_reg[0].singular <= (den == '0);
            ov_reg[0] <= '0;
            for (int l = 0; l < 3; l++)
            begin
                n_reg[0][l] <= {unum[l][HI-1:0], {(64-HI){1'b0}}};
                r_reg[0][l] <= (DW+1)'(unum[l][DW-1:HI]);
                q_reg[0][l] <= '0;
                ng_reg[0][l] <= num[l][DW-1] ^ den[DW-1];
            end
            for (int s = 0; s < QW; s++)
            begin
                d_reg[s+1] <= d_reg[s];
                sd_reg[s+1] <= sd_reg[s];
                ng_reg[s+1] <= ng_reg[s];
                for (int l = 0; l < 3; l++)
                begin
                    logic [DW+1:0] t;
                    t = {r_reg[s][l], n_reg[s][l][63]} - {2'b0, d_reg[s]};
                    // quotient too wide for the lane when the preload reaches the divisor
                    ov_reg[s+1][l] <= ov_reg[s][l]
                        || ((s == 0) && (r_reg[s][l] >= {1'b0, d_reg[s]}));
                    n_reg[s+1][l] <= {n_reg[s][l][62:0], 1'b0};
                    if (!t[DW+1])
                    begin
                        r_reg[s+1][l] <= t[DW:0];
                        q_reg[s+1][l] <= {q_reg[s][l][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[s+1][l] <= {r_reg[s][l][DW-1:0], n_reg[s][l][63]};
                        q_reg[s+1][l] <= {q_reg[s][l][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // an oversized quotient reads as all ones so it clamps downstream
    assign out_valid = v_reg[QW];
    assign quo[0] = ov_reg[QW][0] ? {QW{1'b1}} : q_reg[QW][0];
    assign quo[1] = ov_reg[QW][1] ? {QW{1'b1}} : q_reg[QW][1];
    assign quo[2] = ov_reg[QW][2] ? {QW{1'b1}} : q_reg[QW][2];
    assign neg = ng_reg[QW];
    assign side = sd_reg[QW];

endmodule

[src/solve_3x3_linear_system_core.sv]
// Cramer's rule solver for one 3x3 system per item. Accepts one item every
// cycle while the pipe is not stalled. The pipe holds three determinant
// stages, a divider load stage, 34 restoring stages (one quotient bit each)
// and the output register. The whole pipe advances only when the output
// register is free or being read, so a stall holds every item in place.
`include "solve_3x3_linear_system_core_assert.svh"
module solve_3x3_linear_system_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] a_r0c0,
    input  logic signed [15:0] a_r0c1,
    input  logic signed [15:0] a_r0c2,
    input  logic signed [15:0] a_r1c0,
    input  logic signed [15:0] a_r1c1,
    input  logic signed [15:0] a_r1c2,
    input  logic signed [15:0] a_r2c0,
    input  logic signed [15:0] a_r2c1,
    input  logic signed [15:0] a_r2c2,
    input  logic signed [15:0] rhs0,
    input  logic signed [15:0] rhs1,
    input  logic signed [15:0] rhs2,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] sol0,
    output logic signed [31:0] sol1,
    output logic signed [31:0] sol2,
    output logic               singular,
    output logic               saturated
);

    localparam int QW = s3ls_pkg::QW;

    logic en;
    s3ls_pkg::q88_t m [9];
    s3ls_pkg::q88_t b [3];
    logic det_valid;
    s3ls_pkg::det_t dets [4];
    s3ls_pkg::det_t nums [3];
    logic div_valid;
    logic [QW-1:0] quo [3];
    logic [2:0] neg;
    s3ls_pkg::side_t side;
    logic [31:0] res [3];
    logic [2:0] sat;
    logic ov_reg;
    logic [31:0] sol_reg [3];
    logic sing_reg;
    logic satf_reg;

    assign en = !ov_reg || out_ready;
    assign in_ready = en;

    assign m = '{a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2};
    assign b = '{rhs0, rhs1, rhs2};

    s3ls_det u_det (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid && en),
        .m(m), .b(b), .out_valid(det_valid), .det_out(dets)
    );

    assign nums[0] = dets[1];
    assign nums[1] = dets[2];
    assign nums[2] = dets[3];

    s3ls_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(det_valid),
        .den(dets[0]), .num(nums), .out_valid(div_valid),
        .quo(quo), .neg(neg), .side(side)
    );

    // sign and saturation
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (neg[l])
            begin
                sat[l] = quo[l] > QW'(s3ls_pkg::SatNeg);
                res[l] = sat[l] ? s3ls_pkg::SatNeg : 32'(-quo[l]);
            end
            else
            begin
                sat[l] = quo[l] > QW'(s3ls_pkg::SatPos);
                res[l] = sat[l] ? s3ls_pkg::SatPos : quo[l][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= div_valid;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
                sol_reg[l] <= side.singular ? 32'd0 : res[l];
            sing_reg <= side.singular;
            satf_reg <= !side.singular && (sat != 3'd0);
        end
    end

    assign out_valid = ov_reg;
    assign sol0 = sol_reg[0];
    assign sol1 = sol_reg[1];
    assign sol2 = sol_reg[2];
    assign singular = sing_reg;
    assign saturated = satf_reg;

    `S3_ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && singular,
        sol0 == 32'd0 && sol1 == 32'd0 && sol2 == 32'd0 && !saturated)
    `S3_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(sol0) && $stable(singular))
    `S3_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid, in_ready)

endmodule

[verif/tb_top.sv]
module tb_top;

    // one system of equations and its solution
    typedef struct {
        s3ls_pkg::q88_t a [9];
        s3ls_pkg::q88_t b [3];
    } system_t;

    typedef struct {
        logic signed [31:0] x [3];
        logic               sing;
        logic               sat;
    } solution_t;

    // directed row: system plus optional typed-in answer
    typedef struct {
        system_t   sys;
        bit        known;
        solution_t ans;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    s3ls_pkg::q88_t a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2;
    s3ls_pkg::q88_t rhs0, rhs1, rhs2;
    logic signed [31:0] sol0, sol1, sol2;
    logic singular;
    logic saturated;

    solution_t pending_solutions [$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;

    solve_3x3_linear_system_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_r0c0(a_r0c0), .a_r0c1(a_r0c1), .a_r0c2(a_r0c2),
        .a_r1c0(a_r1c0), .a_r1c1(a_r1c1), .a_r1c2(a_r1c2),
        .a_r2c0(a_r2c0), .a_r2c1(a_r2c1), .a_r2c2(a_r2c2),
        .rhs0(rhs0), .rhs1(rhs1), .rhs2(rhs2),
        .out_valid(out_valid), .out_ready(out_ready),
        .sol0(sol0), .sol1(sol1), .sol2(sol2),
        .singular(singular), .saturated(saturated)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // exact determinant of a row-major 3x3 matrix
    function automatic longint det_of(input longint m [9]);
        return m[0] * (m[4] * m[8] - m[5] * m[7])
             - m[1] * (m[3] * m[8] - m[5] * m[6])
             + m[2] * (m[3] * m[7] - m[4] * m[6]);
    endfunction

    // q16.16 quotient truncated toward zero, clamped to 32 bits
    function automatic logic [31:0] q16_ratio(input longint num, input longint den,
                                              inout logic sat);
        bit neg;
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (un << 16) / ud;
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                sat = 1'b1;
                return s3ls_pkg::SatNeg;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return s3ls_pkg::SatPos;
        end
        return q[31:0];
    endfunction

    // solve by replacing one column at a time
    function automatic solution_t cramer_solve(input system_t s);
        solution_t r;
        longint m [9];
        longint d;
        longint c [9];
        logic sat;
        for (int i = 0; i < 9; i++) m[i] = s.a[i];
        d = det_of(m);
        r.sing = (d == 0);
        sat = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            c = m;
            for (int i = 0; i < 3; i++) c[i*3+j] = s.b[i];
            r.x[j] = (d == 0) ? 32'sd0 : q16_ratio(det_of(c), d, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, exp);
    endtask

    // drive one item, waiting for acceptance; valid drops only while idling
    task automatic send_system(input system_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        {a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2}
            = {s.a[0], s.a[1], s.a[2], s.a[3], s.a[4], s.a[5], s.a[6], s.a[7], s.a[8]};
        {rhs0, rhs1, rhs2} = {s.b[0], s.b[1], s.b[2]};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic system_t random_system();
        system_t s;
        int mode;
        mode = $urandom_range(9);
        for (int i = 0; i < 9; i++)
        begin
            if (mode < 4) s.a[i] = s3ls_pkg::q88_t'($urandom);
            else if (mode < 7) s.a[i] = $signed(10'($urandom)) - 16'sd0;
            else s.a[i] = s3ls_pkg::q88_t'($urandom_range(2) - 1);
        end
        // make a singular matrix now and then: row 2 copies row 0
        if (mode == 9)
            for (int i = 0; i < 3; i++) s.a[6+i] = s.a[i];
        for (int i = 0; i < 3; i++)
            s.b[i] = (mode == 8) ? s3ls_pkg::q88_t'($urandom)
                                 : s3ls_pkg::q88_t'($signed(12'($urandom)));
        return s;
    endfunction

    // receiver: random stall, optional long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            solution_t e;
            if (pending_solutions.size() == 0)
            begin
                errors++;
                $display("result with nothing pending");
            end
            else
            begin
                e = pending_solutions.pop_front();
                if (sol0 !== e.x[0]) report("sol0", sol0, e.x[0]);
                if (sol1 !== e.x[1]) report("sol1", sol1, e.x[1]);
                if (sol2 !== e.x[2]) report("sol2", sol2, e.x[2]);
                if (singular !== e.sing) report("singular", 32'(singular), 32'(e.sing));
                if (saturated !== e.sat) report("saturated", 32'(saturated), 32'(e.sat));
            end
        end
    end

    // run limit
    initial
    begin
        #2000000;
        $display("[solve_3x3_linear_system_core] ERROR");
        $finish;
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t r;
        system_t s;
        solution_t zero_sol;
        int wait_cycles;

        errors = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_valid = 1'b0;
        {a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2} = '0;
        {rhs0, rhs1, rhs2} = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        zero_sol.x = '{0, 0, 0};
        zero_sol.sing = 1'b1;
        zero_sol.sat = 1'b0;

        // all-zero matrix is singular
        r.sys.a = '{default: 0}; r.sys.b = '{16'sh7FFF, -16'sh8000, 1};
        r.known = 1; r.ans = zero_sol; rows.push_back(r);
        // identity, b at extremes
        r.sys.a = '{256, 0, 0, 0, 256, 0, 0, 0, 256}; r.sys.b = '{16'sh7FFF, -16'sh8000, 0};
        r.known = 1; r.ans.x = '{32'h007F_FF00, 32'hFF80_0000, 0};
        r.ans.sing = 0; r.ans.sat = 0; rows.push_back(r);
        // unit determinant: largest quotients, exactly -2^31 is no clamp
        r.sys.a = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; r.sys.b = '{16'sh7FFF, -16'sh8000, 1};
        r.known = 1; r.ans.x = '{32'h7FFF_0000, 32'h8000_0000, 32'h0001_0000};
        r.ans.sing = 0; r.ans.sat = 0; rows.push_back(r);
        // x0 = b0 - b1 with unit determinant saturates high
        r.sys.a = '{1, 1, 0, 0, 1, 0, 0, 0, 1}; r.sys.b = '{16'sh7FFF, -16'sh8000, 1};
        r.known = 1; r.ans.x = '{s3ls_pkg::SatPos, 32'h8000_0000, 32'h0001_0000};
        r.ans.sing = 0; r.ans.sat = 1; rows.push_back(r);
        // same system saturating low
        r.sys.a = '{1, 1, 0, 0, 1, 0, 0, 0, 1}; r.sys.b = '{-16'sh8000, 16'sh7FFF, 0};
        r.known = 1; r.ans.x = '{s3ls_pkg::SatNeg, 32'h7FFF_0000, 0};
        r.ans.sing = 0; r.ans.sat = 1; rows.push_back(r);
        // exactly -2^31 is not a clamp: x0 = -128 / (1/256) = -32768, diag 1, 256, 256
        r.sys.a = '{1, 0, 0, 0, 256, 0, 0, 0, 256}; r.sys.b = '{-16'sh8000, 0, 0};
        r.known = 0; rows.push_back(r);
        // extreme entries everywhere
        r.sys.a = '{default: -16'sh8000}; r.sys.b = '{default: 16'sh7FFF};
        r.known = 1; r.ans = zero_sol; rows.push_back(r);
        r.sys.a = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 0,
                    16'sh7FFF, 0, -16'sh8000};
        r.sys.b = '{-16'sh8000, 16'sh7FFF, -1}; r.known = 0; rows.push_back(r);
        r.sys.a = '{-1, 0, 0, 0, -1, 0, 0, 0, -1}; r.sys.b = '{-1, -1, 16'sh5555};
        r.known = 0; rows.push_back(r);
        r.sys.a = '{0, 256, 0, 256, 0, 0, 0, 0, 16'shAAAA}; r.sys.b = '{3, -7, 16'shAAAA};
        r.known = 0; rows.push_back(r);
        r.sys.a = '{2, 1, 1, 1, 3, 2, 1, 0, 0}; r.sys.b = '{4, 5, 6};
        r.known = 0; rows.push_back(r);
        // singular with equal columns
        r.sys.a = '{5, 5, 1, -3, -3, 2, 7, 7, 9}; r.sys.b = '{1, 2, 3};
        r.known = 1; r.ans = zero_sol; rows.push_back(r);

        // directed part
        foreach (rows[k])
        begin
            pending_solutions.push_back(rows[k].known ? rows[k].ans : cramer_solve(rows[k].sys));
            send_system(rows[k].sys);
        end

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 71 : 0;
            recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 22 : 0;
            for (int n = 0; n < 200; n++)
            begin
                // long receiver hold-off so the pipe fills and backs up
                if (ph == 2 && n == 20)
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (150) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                s = random_system();
                pending_solutions.push_back(cramer_solve(s));
                send_system(s);
            end
        end
        in_valid <= 1'b0;

        // drain
        wait_cycles = 0;
        while (pending_solutions.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (60) @(posedge clk);
        if (errors == 0 && pending_solutions.size() == 0)
            $display("[solve_3x3_linear_system_core] OK");
        else
            $display("[solve_3x3_linear_system_core] ERROR");
        $finish;
    end

endmodule
